/* rtl/tevd_pkg.sv */
// Shared types, codes and sizes for the touch event decoder.
package tevd_pkg;

	localparam int NUM_SLOTS_DEF = 10;
	localparam int SLOT_W        = 4;
	localparam int COORD_W       = 16;
	localparam int DIM_W         = 13;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 13;

	// decoupling queue between decode and transform
	localparam int Q_DEPTH = 2;
	localparam int QPTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

	localparam logic [11:0] DOWNMOVE_BASE_HI = 12'h600;
	localparam logic [11:0] UP_BASE_HI       = 12'h610;
	localparam logic [15:0] CODE_LEGACY_POS  = 16'h0001;
	localparam logic [15:0] CODE_LEGACY_UP   = 16'h0000;
	localparam logic [15:0] TOUCH_KEY        = 16'h014a;

	typedef enum logic [1:0] {
		KIND_ABS   = 2'd0,
		KIND_KEY   = 2'd1,
		KIND_OTHER = 2'd2,
		KIND_RSVD  = 2'd3
	} event_kind_t;

	typedef enum logic [1:0] {
		PH_DOWN = 2'd0,
		PH_MOVE = 2'd1,
		PH_UP   = 2'd2,
		PH_RSVD = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		ROT_AUTO = 2'd0,
		ROT_NONE = 2'd1,
		ROT_90   = 2'd2,
		ROT_270  = 2'd3
	} rot_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROTATION = 2'd0,
		REG_WIDTH    = 2'd1,
		REG_HEIGHT   = 2'd2,
		REG_NONE     = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic [1:0]  event_kind;
		logic [15:0] event_code;
		logic [31:0] event_value;
	} event_t;

	typedef struct packed {
		logic [1:0]         touch_phase;
		logic [SLOT_W-1:0]  touch_slot;
		logic [COORD_W-1:0] touch_x;
		logic [COORD_W-1:0] touch_y;
	} report_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

/* rtl/tevd_front.sv */
// Front end: takes events, keeps contact state, classifies into raw reports.
module tevd_front #(
	parameter int NUM_SLOTS = tevd_pkg::NUM_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  tevd_pkg::event_t  ev,
	output logic              rpt_valid,
	output tevd_pkg::report_t rpt
);

	localparam logic [tevd_pkg::SLOT_W:0] SLOT_LIM = (tevd_pkg::SLOT_W + 1)'(NUM_SLOTS);

	logic [NUM_SLOTS-1:0] contact_q;
	logic                 legacy_q;
	logic [15:0]          legacy_x_q;
	logic [15:0]          legacy_y_q;

	logic [NUM_SLOTS-1:0]         slot_oh;
	logic [tevd_pkg::SLOT_W-1:0]  slot;
	logic                         slot_ok;
	logic                         is_abs;
	logic                         hit_dm;
	logic                         hit_up;
	logic                         hit_lpos;
	logic                         hit_lup;
	logic                         slot_busy;
	logic [15:0]                  px;
	logic [15:0]                  py;

	assign slot    = ev.event_code[tevd_pkg::SLOT_W-1:0];
	assign slot_ok = {1'b0, slot} < SLOT_LIM;
	assign is_abs  = ev.event_kind == tevd_pkg::KIND_ABS;
	assign px      = ev.event_value[31:16];
	assign py      = ev.event_value[15:0];

	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			slot_oh[i] = slot == tevd_pkg::SLOT_W'(i);
		end
	end

	assign slot_busy = |(contact_q & slot_oh);

	assign hit_dm   = is_abs && ev.event_code[15:4] == tevd_pkg::DOWNMOVE_BASE_HI && slot_ok;
	assign hit_up   = is_abs && ev.event_code[15:4] == tevd_pkg::UP_BASE_HI && slot_ok;
	assign hit_lpos = is_abs && ev.event_code == tevd_pkg::CODE_LEGACY_POS;
	// legacy lift: axis code zero, or touch-key release
	assign hit_lup  = legacy_q &&
		((is_abs && ev.event_code == tevd_pkg::CODE_LEGACY_UP) ||
		 (ev.event_kind == tevd_pkg::KIND_KEY && ev.event_code == tevd_pkg::TOUCH_KEY &&
		  ev.event_value == 32'd0));

	assign rpt_valid = accept && (hit_dm || hit_up || hit_lpos || hit_lup);

	always_comb begin
		rpt.touch_phase = tevd_pkg::PH_UP;
		rpt.touch_slot  = '0;
		rpt.touch_x     = legacy_x_q;
		rpt.touch_y     = legacy_y_q;
		priority if (hit_dm) begin
			rpt.touch_phase = slot_busy ? tevd_pkg::PH_MOVE : tevd_pkg::PH_DOWN;
			rpt.touch_slot  = slot;
			rpt.touch_x     = px;
			rpt.touch_y     = py;
		end else if (hit_up) begin
			rpt.touch_slot = slot;
			rpt.touch_x    = px;
			rpt.touch_y    = py;
		end else if (hit_lpos) begin
			rpt.touch_phase = legacy_q ? tevd_pkg::PH_MOVE : tevd_pkg::PH_DOWN;
			rpt.touch_x     = px;
			rpt.touch_y     = py;
		end else begin
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			contact_q  <= '0;
			legacy_q   <= 1'b0;
			legacy_x_q <= '0;
			legacy_y_q <= '0;
		end else if (accept) begin
			priority if (hit_dm) begin
				contact_q <= contact_q | slot_oh;
			end else if (hit_up) begin
				contact_q <= contact_q & ~slot_oh;
			end else if (hit_lpos) begin
				contact_q[0] <= 1'b1;
				legacy_q     <= 1'b1;
				legacy_x_q   <= px;
				legacy_y_q   <= py;
			end else if (hit_lup) begin
				contact_q[0] <= 1'b0;
				legacy_q     <= 1'b0;
			end else begin
			end
		end
	end

endmodule

/* rtl/tevd_queue.sv */
// Short report queue between the decode front and the transform back end.
module tevd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  tevd_pkg::report_t wdata,
	input  logic              rd,
	output tevd_pkg::report_t rdata,
	output tevd_pkg::qstat_t  stat
);

	localparam logic [tevd_pkg::QPTR_W-1:0] PTR_LAST = tevd_pkg::QPTR_W'(tevd_pkg::Q_DEPTH - 1);
	localparam logic [tevd_pkg::QCNT_W-1:0] CNT_FULL = tevd_pkg::QCNT_W'(tevd_pkg::Q_DEPTH);

	tevd_pkg::report_t              mem_q [tevd_pkg::Q_DEPTH];
	logic [tevd_pkg::QPTR_W-1:0]    wptr_q;
	logic [tevd_pkg::QPTR_W-1:0]    rptr_q;
	logic [tevd_pkg::QCNT_W-1:0]    cnt_q;
	logic                           do_wr;
	logic                           do_rd;

	assign stat.full  = cnt_q == CNT_FULL;
	assign stat.empty = cnt_q == '0;
	assign do_wr      = wr && !stat.full;
	assign do_rd      = rd && !stat.empty;
	assign rdata      = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PTR_LAST) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PTR_LAST) ? '0 : rptr_q + 1'b1;
			end
			unique case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* rtl/tevd_back.sv */
// Back end: config registers, rotation and clamp, output register.
module tevd_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [tevd_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [tevd_pkg::CFG_DATA_W-1:0]   wr_data,
	input  tevd_pkg::qstat_t                  qstat,
	input  tevd_pkg::report_t                 head,
	output logic                              q_rd,
	input  logic                              pop,
	output logic                              empty,
	output tevd_pkg::report_t                 report
);

	localparam int CW = tevd_pkg::COORD_W + 2;

	logic [1:0]                  rot_q;
	logic [tevd_pkg::DIM_W-1:0]  width_q;
	logic [tevd_pkg::DIM_W-1:0]  height_q;

	logic                        out_valid_q;
	tevd_pkg::report_t           out_q;

	logic                        size_ok;
	logic [1:0]                  mode;
	logic signed [CW-1:0]        xs;
	logic signed [CW-1:0]        ys;
	logic signed [CW-1:0]        ws;
	logic signed [CW-1:0]        hs;
	logic signed [CW-1:0]        xr;
	logic signed [CW-1:0]        yr;
	logic signed [CW-1:0]        xc;
	logic signed [CW-1:0]        yc;
	tevd_pkg::report_t           xf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q    <= tevd_pkg::ROT_AUTO;
			width_q  <= '0;
			height_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				tevd_pkg::REG_ROTATION: rot_q    <= wr_data[1:0];
				tevd_pkg::REG_WIDTH:    width_q  <= wr_data[tevd_pkg::DIM_W-1:0];
				tevd_pkg::REG_HEIGHT:   height_q <= wr_data[tevd_pkg::DIM_W-1:0];
				default: ;
			endcase
		end
	end

	assign size_ok = width_q != '0 && height_q != '0;
	assign xs = CW'(signed'({2'b00, head.touch_x}));
	assign ys = CW'(signed'({2'b00, head.touch_y}));
	assign ws = CW'(signed'({5'b00000, width_q}));
	assign hs = CW'(signed'({5'b00000, height_q}));

	always_comb begin
		mode = rot_q;
		if (rot_q == tevd_pkg::ROT_AUTO) begin
			mode = (width_q > height_q) ? tevd_pkg::ROT_90 : tevd_pkg::ROT_NONE;
		end
		unique case (mode)
			tevd_pkg::ROT_90: begin
				xr = ys;
				yr = hs - CW'(1) - xs;
			end
			tevd_pkg::ROT_270: begin
				xr = ws - CW'(1) - ys;
				yr = xs;
			end
			default: begin
				xr = xs;
				yr = ys;
			end
		endcase
		priority if (xr < 0)   xc = '0;
		else if (xr >= ws)     xc = ws - CW'(1);
		else                   xc = xr;
		priority if (yr < 0)   yc = '0;
		else if (yr >= hs)     yc = hs - CW'(1);
		else                   yc = yr;

		xf = head;
		if (size_ok) begin
			xf.touch_x = xc[tevd_pkg::COORD_W-1:0];
			xf.touch_y = yc[tevd_pkg::COORD_W-1:0];
		end
	end

	// output register refills in the same cycle its result transfers out
	assign q_rd   = !qstat.empty && (!out_valid_q || pop);
	assign empty  = !out_valid_q;
	assign report = out_q;

	always_ff @(posedge clk) begin
		if (q_rd) begin
			out_q <= xf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_rd) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

/* rtl/touch_event_decoder_core.sv */
// Top level of the touch event decoder.
//
//  channel   dir  handshake       payload
//  events    in   push / full     raw_event (event_kind, event_code, event_value)
//  reports   out  empty / pop     report (touch_phase, touch_slot, touch_x, touch_y)
//  config    in   wr_en           wr_index, wr_data (0 rotation, 1 width, 2 height)
//
// One event is taken per cycle while the report queue has room.
// A report is written into the queue at the edge that accepts its event, then moves through
// the transform into the output register when that register is empty or being popped.
// full rises only when the output register is held and the two-entry queue is full.
// arst_n clears contact state, the queue pointers and count, the output valid flag and the config registers.
module touch_event_decoder_core #(
	parameter int NUM_SLOTS = tevd_pkg::NUM_SLOTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  tevd_pkg::event_t                  raw_event,
	output logic                              empty,
	input  logic                              pop,
	output tevd_pkg::report_t                 report,
	input  logic                              wr_en,
	input  logic [tevd_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [tevd_pkg::CFG_DATA_W-1:0]   wr_data
);

	tevd_pkg::qstat_t  qstat;
	tevd_pkg::report_t fr_rpt;
	tevd_pkg::report_t q_head;
	logic              fr_valid;
	logic              q_rd;
	logic              accept;

	assign full   = qstat.full;
	assign accept = push && !qstat.full;

	tevd_front #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.ev       (raw_event),
		.rpt_valid(fr_valid),
		.rpt      (fr_rpt)
	);

	tevd_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (fr_valid),
		.wdata (fr_rpt),
		.rd    (q_rd),
		.rdata (q_head),
		.stat  (qstat)
	);

	tevd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_index(wr_index),
		.wr_data (wr_data),
		.qstat   (qstat),
		.head    (q_head),
		.q_rd    (q_rd),
		.pop     (pop),
		.empty   (empty),
		.report  (report)
	);

endmodule

/* rtl/tevd_checker.sv */
// Port-level checks for the touch event decoder, bound to the top level.
module tevd_checker #(
	parameter int NUM_SLOTS = tevd_pkg::NUM_SLOTS_DEF
) (
	input logic              clk,
	input logic              arst_n,
	input logic              full,
	input logic              empty,
	input logic              pop,
	input tevd_pkg::report_t report
);

	// reset leaves nothing to transfer and room for events
	a_reset_idle: assert property (@(posedge clk) !arst_n |-> empty && !full)
		else $error("reset state not idle");

	// a held report stays put until its transfer
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(report))
		else $error("stalled report changed");

	// the queue only backs up behind a held output report
	a_full_held: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !empty)
		else $error("full without a pending report");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ({1'b0, report.touch_slot} < (tevd_pkg::SLOT_W + 1)'(NUM_SLOTS)) &&
		           report.touch_phase != tevd_pkg::PH_RSVD)
		else $error("report slot or phase out of range");

endmodule

bind touch_event_decoder_core tevd_checker #(
	.NUM_SLOTS(NUM_SLOTS)
) u_tevd_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.full  (full),
	.empty (empty),
	.pop   (pop),
	.report(report)
);

/* dv/tb_touch_event_decoder_core.sv */
`timescale 1ns / 100ps
// Self-checking testbench for touch_event_decoder_core: directed and random events against a local decoder model.
module tb_touch_event_decoder_core;
	import tevd_pkg::*;

	localparam int NUM_SLOTS     = NUM_SLOTS_DEF;
	localparam int DOWNMOVE_BASE = {DOWNMOVE_BASE_HI, 4'h0};
	localparam int UP_BASE       = {UP_BASE_HI, 4'h0};
	localparam int RANDOM_EVENTS  = 920;
	localparam int PHASES         = 10;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  push;
	logic                  full;
	event_t                raw_event;
	logic                  empty;
	logic                  pop;
	report_t               report;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	// decoder model state and its copy of the screen registers
	rot_mode_t             cur_rot = ROT_AUTO;
	int                    cur_width = 0;
	int                    cur_height = 0;
	logic [NUM_SLOTS-1:0]  contact_busy = '0;
	logic                  legacy_active = 1'b0;
	logic [15:0]           legacy_x = '0;
	logic [15:0]           legacy_y = '0;

	report_t               pending_reports[$];
	int                    mismatches = 0;

	touch_event_decoder_core #(
		.NUM_SLOTS(NUM_SLOTS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.raw_event(raw_event),
		.empty    (empty),
		.pop      (pop),
		.report   (report),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic report_t map_to_screen(phase_t ph, int slot, logic [15:0] xin,
			logic [15:0] yin);
		report_t   r;
		rot_mode_t mode;
		int        rx;
		int        ry;
		int        x;
		int        y;
		rx = xin;
		ry = yin;
		x = rx;
		y = ry;
		if (cur_width > 0 && cur_height > 0) begin
			mode = cur_rot;
			if (mode == ROT_AUTO) begin
				if (cur_width > cur_height)
					mode = ROT_90;
				else
					mode = ROT_NONE;
			end
			if (mode == ROT_90) begin
				x = ry;
				y = cur_height - 1 - rx;
			end else if (mode == ROT_270) begin
				x = cur_width - 1 - ry;
				y = rx;
			end
			if (x < 0)
				x = 0;
			else if (x >= cur_width)
				x = cur_width - 1;
			if (y < 0)
				y = 0;
			else if (y >= cur_height)
				y = cur_height - 1;
		end
		r.touch_phase = ph;
		r.touch_slot  = SLOT_W'(slot);
		r.touch_x     = COORD_W'(x);
		r.touch_y     = COORD_W'(y);
		return r;
	endfunction

	// Updates the contact state for one event; returns 1 when the event yields a report.
	function automatic bit decode_touch(input event_t ev, output report_t r);
		logic [15:0] px;
		logic [15:0] py;
		int          code;
		int          s;
		phase_t      ph;
		px = ev.event_value[31:16];
		py = ev.event_value[15:0];
		code = ev.event_code;
		r = '0;
		if (ev.event_kind == KIND_ABS) begin
			if (code >= DOWNMOVE_BASE && code < DOWNMOVE_BASE + NUM_SLOTS) begin
				s = code - DOWNMOVE_BASE;
				if (contact_busy[s])
					ph = PH_MOVE;
				else
					ph = PH_DOWN;
				contact_busy[s] = 1'b1;
				r = map_to_screen(ph, s, px, py);
				return 1'b1;
			end
			if (code >= UP_BASE && code < UP_BASE + NUM_SLOTS) begin
				s = code - UP_BASE;
				contact_busy[s] = 1'b0;
				r = map_to_screen(PH_UP, s, px, py);
				return 1'b1;
			end
			if (ev.event_code == CODE_LEGACY_POS) begin
				if (legacy_active)
					ph = PH_MOVE;
				else
					ph = PH_DOWN;
				legacy_active = 1'b1;
				contact_busy[0] = 1'b1;
				legacy_x = px;
				legacy_y = py;
				r = map_to_screen(ph, 0, legacy_x, legacy_y);
				return 1'b1;
			end
			if (ev.event_code == CODE_LEGACY_UP && legacy_active) begin
				legacy_active = 1'b0;
				contact_busy[0] = 1'b0;
				r = map_to_screen(PH_UP, 0, legacy_x, legacy_y);
				return 1'b1;
			end
			return 1'b0;
		end
		if (ev.event_kind == KIND_KEY && ev.event_code == TOUCH_KEY &&
				ev.event_value == 32'd0 && legacy_active) begin
			legacy_active = 1'b0;
			contact_busy[0] = 1'b0;
			r = map_to_screen(PH_UP, 0, legacy_x, legacy_y);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic event_t mk_event(event_kind_t kind, int code, logic [31:0] value);
		event_t ev;
		ev.event_kind  = kind;
		ev.event_code  = 16'(code);
		ev.event_value = value;
		return ev;
	endfunction

	function automatic logic [15:0] rand_coord();
		case ($urandom_range(0, 4))
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 8400));
			2: return 16'($urandom_range(0, cur_width + 2));
			3: return 16'h0000;
			default: return 16'hffff;
		endcase
	endfunction

	function automatic int pick_dim();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 1;
			2: return 8191;
			3: return $urandom_range(1, 64);
			default: return $urandom_range(1, 8191);
		endcase
	endfunction

	task automatic send_event(input event_t ev);
		int      gap;
		report_t r;
		gap = $urandom_range(0, 3);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		raw_event <= ev;
		push <= 1'b1;
		do @(posedge clk); while (full !== 1'b0);
		if (decode_touch(ev, r)) begin
			pending_reports.push_back(r);
		end
	endtask

	// Wait until every predicted report has been popped, plus pipeline slack.
	task automatic settle_reports();
		push <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(rot_mode_t rot, int width, int height);
		settle_reports();
		wr_en <= 1'b1;
		wr_index <= REG_ROTATION;
		wr_data <= CFG_DATA_W'(rot);
		@(posedge clk);
		wr_index <= REG_WIDTH;
		wr_data <= CFG_DATA_W'(width);
		@(posedge clk);
		wr_index <= REG_HEIGHT;
		wr_data <= CFG_DATA_W'(height);
		@(posedge clk);
		// unused index: must leave every register alone
		wr_index <= REG_NONE;
		wr_data <= CFG_DATA_W'($urandom);
		@(posedge clk);
		wr_en <= 1'b0;
		cur_rot = rot;
		cur_width = width;
		cur_height = height;
	endtask

	task automatic check_field(string name, int exp_val, int act_val);
		if (exp_val != act_val) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_val,
				act_val);
		end
	endtask

	// Reset screen size is zero, so these run with pass-through coordinates.
	task automatic test_slot_path();
		send_event(mk_event(KIND_ABS, DOWNMOVE_BASE, 32'hffff_ffff));
		send_event(mk_event(KIND_ABS, DOWNMOVE_BASE, 32'h0000_0000));
		send_event(mk_event(KIND_ABS, UP_BASE, 32'h1234_5678));
		send_event(mk_event(KIND_ABS, DOWNMOVE_BASE + NUM_SLOTS - 1, 32'h8000_0001));
		send_event(mk_event(KIND_ABS, UP_BASE + NUM_SLOTS - 1, 32'h0000_0000));
		// up on a slot that was never down still reports
		send_event(mk_event(KIND_ABS, UP_BASE + 3, 32'h5555_aaaa));
	endtask

	task automatic test_legacy_path();
		send_event(mk_event(KIND_ABS, CODE_LEGACY_UP, 32'h0102_0304));
		send_event(mk_event(KIND_KEY, TOUCH_KEY, 32'h0000_0000));
		send_event(mk_event(KIND_ABS, CODE_LEGACY_POS, 32'h0010_0020));
		send_event(mk_event(KIND_ABS, CODE_LEGACY_POS, 32'h7fff_8000));
		// slot-path up clears slot 0 only; legacy touch stays active
		send_event(mk_event(KIND_ABS, UP_BASE, 32'h0001_0001));
		send_event(mk_event(KIND_ABS, CODE_LEGACY_UP, 32'hdead_beef));
		send_event(mk_event(KIND_ABS, CODE_LEGACY_POS, 32'h00ff_ff00));
		send_event(mk_event(KIND_KEY, TOUCH_KEY, 32'h0000_0001));
		send_event(mk_event(KIND_KEY, TOUCH_KEY, 32'h0000_0000));
	endtask

	task automatic test_ignored_events();
		send_event(mk_event(KIND_OTHER, DOWNMOVE_BASE, 32'h1111_2222));
		send_event(mk_event(KIND_RSVD, CODE_LEGACY_POS, 32'h3333_4444));
		send_event(mk_event(KIND_ABS, DOWNMOVE_BASE + NUM_SLOTS, 32'h0000_0000));
		send_event(mk_event(KIND_ABS, UP_BASE + 15, 32'hffff_ffff));
		send_event(mk_event(KIND_KEY, TOUCH_KEY + 1, 32'h0000_0000));
		send_event(mk_event(KIND_ABS, 16'hffff, 32'hffff_ffff));
	endtask

	task automatic test_rotation();
		configure(ROT_AUTO, 800, 480);
		send_event(mk_event(KIND_ABS, DOWNMOVE_BASE + 1, {16'd900, 16'd100}));
		send_event(mk_event(KIND_ABS, UP_BASE + 1, {16'hffff, 16'h0000}));
		configure(ROT_AUTO, 480, 800);
		send_event(mk_event(KIND_ABS, DOWNMOVE_BASE + 1, {16'd900, 16'd100}));
		send_event(mk_event(KIND_ABS, UP_BASE + 1, {16'hffff, 16'h0000}));
		configure(ROT_90, 8191, 8191);
		send_event(mk_event(KIND_ABS, DOWNMOVE_BASE + 1, {16'd9000, 16'd10}));
		send_event(mk_event(KIND_ABS, UP_BASE + 1, {16'h0000, 16'hffff}));
		configure(ROT_270, 1, 1);
		send_event(mk_event(KIND_ABS, DOWNMOVE_BASE + 1, {16'd0, 16'd0}));
		send_event(mk_event(KIND_ABS, UP_BASE + 1, {16'hffff, 16'hffff}));
		// one zero dimension disables rotation and clamp
		configure(ROT_NONE, 0, 600);
		send_event(mk_event(KIND_ABS, DOWNMOVE_BASE + 1, {16'hfedc, 16'hba98}));
		send_event(mk_event(KIND_ABS, UP_BASE + 1, {16'h0123, 16'h4567}));
	endtask

	task automatic test_random();
		int     sel;
		int     slot;
		event_t ev;
		for (int phase = 0; phase < PHASES; phase++) begin
			configure(rot_mode_t'($urandom_range(0, 3)), pick_dim(), pick_dim());
			for (int n = 0; n < RANDOM_EVENTS / PHASES; n++) begin
				slot = $urandom_range(0, NUM_SLOTS - 1);
				sel = $urandom_range(0, 99);
				if (sel < 40)
					ev = mk_event(KIND_ABS, DOWNMOVE_BASE + slot, {rand_coord(), rand_coord()});
				else if (sel < 55)
					ev = mk_event(KIND_ABS, UP_BASE + slot, {rand_coord(), rand_coord()});
				else if (sel < 68)
					ev = mk_event(KIND_ABS, CODE_LEGACY_POS, {rand_coord(), rand_coord()});
				else if (sel < 76)
					ev = mk_event(KIND_ABS, CODE_LEGACY_UP, $urandom);
				else if (sel < 84)
					ev = mk_event(KIND_KEY, TOUCH_KEY, $urandom_range(0, 1) ? 32'd0 : $urandom);
				else if (sel < 88)
					ev = mk_event(KIND_ABS, ($urandom_range(0, 1) ? DOWNMOVE_BASE : UP_BASE) +
						$urandom_range(NUM_SLOTS, 15), $urandom);
				else if (sel < 94)
					ev = mk_event(KIND_ABS, $urandom, $urandom);
				else
					ev = mk_event(event_kind_t'($urandom_range(1, 3)), $urandom, $urandom);
				send_event(ev);
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		push <= 1'b0;
		raw_event <= '0;
		wr_en <= 1'b0;
		wr_index <= REG_ROTATION;
		wr_data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_slot_path();
		test_legacy_path();
		test_ignored_events();
		test_rotation();
		test_random();
		settle_reports();
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin : report_checker
		report_t exp_rep;
		int      gap;
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = $urandom_range(0, 3);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty !== 1'b0);
			if (pending_reports.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected report transfer, expected none actual %0d/%0d/%0d/%0d",
					$time, report.touch_phase, report.touch_slot, report.touch_x,
					report.touch_y);
			end else begin
				exp_rep = pending_reports.pop_front();
				check_field("touch_phase", exp_rep.touch_phase, report.touch_phase);
				check_field("touch_slot", exp_rep.touch_slot, report.touch_slot);
				check_field("touch_x", exp_rep.touch_x, report.touch_x);
				check_field("touch_y", exp_rep.touch_y, report.touch_y);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

/* filelist.f */
rtl/tevd_pkg.sv
rtl/tevd_front.sv
rtl/tevd_queue.sv
rtl/tevd_back.sv
rtl/touch_event_decoder_core.sv
rtl/tevd_checker.sv
dv/tb_touch_event_decoder_core.sv
